FILE: src/sphere_box_contact_assert.svh
// Assertion macros for the sphere to box contact block.
// Included by the top level; uses no package.
`ifndef SPHERE_BOX_CONTACT_ASSERT_SVH
`define SPHERE_BOX_CONTACT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sbc_pkg.sv
// Types, constants and rounding helpers for the sphere to box contact block.
// Used by the interfaces, the pipelined units and the top level.
`default_nettype none
package sbc_pkg;

    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned DivSteps  = 32;

    localparam logic signed [31:0] QOne = 32'sd1073741824;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    typedef struct packed {
        logic signed [31:0] ball_x;
        logic signed [31:0] ball_y;
        logic signed [31:0] ball_z;
        logic [30:0]        ball_radius;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic signed [31:0] box_z;
        logic signed [31:0] box_qw;
        logic signed [31:0] box_qx;
        logic signed [31:0] box_qy;
        logic signed [31:0] box_qz;
        logic [30:0]        box_width;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [31:0] contact_z;
        logic [30:0]        depth;
    } t_rsp;

    typedef struct packed {
        logic [8:0][31:0] m;
        logic [2:0][31:0] ball;
        logic [30:0]      rad;
        logic             hit;
        logic             szero;
        logic [2:0]       gneg;
        t_axis            ax;
        logic             axneg;
        logic [2:0][30:0] an;
    } t_side;

    // divide by 2^k, round half away from zero
    function automatic logic signed [65:0] rshr(input logic signed [65:0] v, input int k);
        logic signed [65:0] half;
        half = 66'sd1 <<< (k - 1);
        if (v >= 0) begin
            return (v + half) >>> k;
        end
        return -((-v + half) >>> k);
    endfunction

    function automatic logic signed [31:0] clamp_q(input logic signed [65:0] v);
        if (v > 66'sd1073741824) begin
            return QOne;
        end
        if (v < -66'sd1073741824) begin
            return -QOne;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_i32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/sbc_req_if.sv
// Request channel of the sphere to box contact block.
// Depends on sbc_pkg for the request payload type.
`default_nettype none
interface sbc_req_if;
    import sbc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sbc_rsp_if.sv
// Result channel of the sphere to box contact block.
// Depends on sbc_pkg for the result payload type.
`default_nettype none
interface sbc_rsp_if;
    import sbc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/sbc_isqrt.sv
// Pipelined floor square root of a 64 bit value, one result bit per stage.
// Depends on sbc_pkg for the stage count.
`default_nettype none
module sbc_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_val,
    output logic [31:0]      o_root
);
    import sbc_pkg::*;

    logic [63:0] r_v [SqrtSteps];
    logic [63:0] r_r [SqrtSteps];

    for (genvar g = 0; g < SqrtSteps; g++) begin : g_stage
        logic [63:0] v_in, r_in, bitv, t, n_v, n_r;
        if (g == 0) begin : g_first
            assign v_in = i_val;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[g-1];
            assign r_in = r_r[g-1];
        end
        assign bitv = 64'd1 << (62 - 2 * g);
        assign t    = r_in + bitv;
        always_comb begin
            if (v_in >= t) begin
                n_v = v_in - t;
                n_r = (r_in >> 1) + bitv;
            end else begin
                n_v = v_in;
                n_r = r_in >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[g] <= n_v;
                r_r[g] <= n_r;
            end
        end
    end

    assign o_root = r_r[SqrtSteps-1][31:0];
endmodule
`default_nettype wire

FILE: src/sbc_div.sv
// Pipelined restoring divider: 62 bit dividend by 32 bit divisor, one
// quotient bit per stage. Expects the top 30 dividend bits below the divisor.
`default_nettype none
module sbc_div (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [61:0] i_num,
    input  wire logic [31:0] i_den,
    output logic [31:0]      o_quo
);
    import sbc_pkg::*;

    logic [31:0] r_rem [DivSteps];
    logic [31:0] r_lo  [DivSteps];
    logic [31:0] r_quo [DivSteps];
    logic [31:0] r_den [DivSteps];

    for (genvar g = 0; g < DivSteps; g++) begin : g_stage
        logic [31:0] rem_in, lo_in, quo_in, den_in, n_rem;
        logic [32:0] t;
        logic        qb;
        if (g == 0) begin : g_first
            assign rem_in = {2'b00, i_num[61:32]};
            assign lo_in  = i_num[31:0];
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign lo_in  = r_lo[g-1];
            assign quo_in = r_quo[g-1];
            assign den_in = r_den[g-1];
        end
        assign t  = {rem_in, lo_in[31]};
        assign qb = t >= {1'b0, den_in};
        always_comb begin
            if (qb) begin
                n_rem = 32'(t - {1'b0, den_in});
            end else begin
                n_rem = t[31:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_lo[g]  <= {lo_in[30:0], 1'b0};
                r_quo[g] <= {quo_in[30:0], qb};
                r_den[g] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[DivSteps-1];
endmodule
`default_nettype wire

FILE: src/sphere_box_contact.sv
// Sphere to oriented box contact test, fully pipelined. Most of the
// pipeline is the two 32-stage square root units and the 32-stage divider.
// Throughput: one request per cycle; the pipeline stalls only when its last
// stage and the output register are both full and the result is not taken.
// Reset clears valid bits only and holds the request side not ready.
`default_nettype none
`include "sphere_box_contact_assert.svh"
module sphere_box_contact (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbc_req_if.sink    i_req,
    sbc_rsp_if.source  o_rsp
);
    import sbc_pkg::*;

    localparam int unsigned NumStages = 10 + SqrtSteps + DivSteps + 3;
    localparam int unsigned SideLen   = SqrtSteps + DivSteps;

    logic [NumStages-1:0] r_vld;
    logic                 r_o_valid;
    t_rsp                 r_o_data, n_o_data;
    logic                 out_take, adv;

    assign out_take    = !r_o_valid || o_rsp.ready;
    assign adv         = out_take || !r_vld[NumStages-1];
    assign i_req.ready = adv && i_rst_n;
    assign o_rsp.valid = r_o_valid;
    assign o_rsp.data  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[NumStages-2:0], i_req.valid};
            end
            if (out_take) begin
                r_o_valid <= r_vld[NumStages-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_o_data <= n_o_data;
        end
    end

    // stage 1: offset and quaternion clamp
    logic signed [32:0] r1_d [3];
    logic signed [31:0] r1_q [4];
    logic [2:0][31:0]   r1_ball;
    logic [30:0]        r1_rad, r1_wid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_d[0] <= {i_req.data.ball_x[31], i_req.data.ball_x}
                     - {i_req.data.box_x[31], i_req.data.box_x};
            r1_d[1] <= {i_req.data.ball_y[31], i_req.data.ball_y}
                     - {i_req.data.box_y[31], i_req.data.box_y};
            r1_d[2] <= {i_req.data.ball_z[31], i_req.data.ball_z}
                     - {i_req.data.box_z[31], i_req.data.box_z};
            r1_q[0] <= clamp_q(66'(i_req.data.box_qw));
            r1_q[1] <= clamp_q(66'(i_req.data.box_qx));
            r1_q[2] <= clamp_q(66'(i_req.data.box_qy));
            r1_q[3] <= clamp_q(66'(i_req.data.box_qz));
            r1_ball <= {i_req.data.ball_z, i_req.data.ball_y, i_req.data.ball_x};
            r1_rad  <= i_req.data.ball_radius;
            r1_wid  <= i_req.data.box_width;
        end
    end

    // stage 2: quaternion products xx yy zz xy xz yz wx wy wz
    logic signed [63:0] r2_pr [9];
    logic signed [32:0] r2_d [3];
    logic [2:0][31:0]   r2_ball;
    logic [30:0]        r2_rad, r2_wid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pr[0] <= r1_q[1] * r1_q[1];
            r2_pr[1] <= r1_q[2] * r1_q[2];
            r2_pr[2] <= r1_q[3] * r1_q[3];
            r2_pr[3] <= r1_q[1] * r1_q[2];
            r2_pr[4] <= r1_q[1] * r1_q[3];
            r2_pr[5] <= r1_q[2] * r1_q[3];
            r2_pr[6] <= r1_q[0] * r1_q[1];
            r2_pr[7] <= r1_q[0] * r1_q[2];
            r2_pr[8] <= r1_q[0] * r1_q[3];
            r2_d     <= r1_d;
            r2_ball  <= r1_ball;
            r2_rad   <= r1_rad;
            r2_wid   <= r1_wid;
        end
    end

    // stage 3: rotation matrix, row major
    logic signed [31:0] r3_m [9];
    logic signed [32:0] r3_d [3];
    logic [2:0][31:0]   r3_ball;
    logic [30:0]        r3_rad, r3_wid;
    logic signed [65:0] e [9];

    always_comb begin
        logic signed [65:0] p [9];
        logic signed [65:0] one;
        one = 66'sd1 <<< 60;
        for (int k = 0; k < 9; k++) begin
            p[k] = 66'(r2_pr[k]);
        end
        e[0] = one - 66'sd2 * (p[1] + p[2]);
        e[1] = 66'sd2 * (p[3] - p[8]);
        e[2] = 66'sd2 * (p[4] + p[7]);
        e[3] = 66'sd2 * (p[3] + p[8]);
        e[4] = one - 66'sd2 * (p[0] + p[2]);
        e[5] = 66'sd2 * (p[5] - p[6]);
        e[6] = 66'sd2 * (p[4] - p[7]);
        e[7] = 66'sd2 * (p[5] + p[6]);
        e[8] = one - 66'sd2 * (p[0] + p[1]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r3_m[k] <= clamp_q(rshr(e[k], 30));
            end
            r3_d    <= r2_d;
            r3_ball <= r2_ball;
            r3_rad  <= r2_rad;
            r3_wid  <= r2_wid;
        end
    end

    // stage 4: transposed matrix times offset
    logic signed [64:0] r4_p [9];
    logic signed [31:0] r4_m [9];
    logic [2:0][31:0]   r4_ball;
    logic [30:0]        r4_rad, r4_wid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_p[i*3+j] <= r3_m[j*3+i] * r3_d[j];
                end
            end
            r4_m    <= r3_m;
            r4_ball <= r3_ball;
            r4_rad  <= r3_rad;
            r4_wid  <= r3_wid;
        end
    end

    // stage 5: box-space position in half-LSB units
    logic signed [35:0] r5_lp [3];
    logic signed [31:0] r5_m [9];
    logic [2:0][31:0]   r5_ball;
    logic [30:0]        r5_rad, r5_wid;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r5_lp[i] <= 36'(rshr(66'(r4_p[i*3]), 29) + rshr(66'(r4_p[i*3+1]), 29)
                              + rshr(66'(r4_p[i*3+2]), 29));
            end
            r5_m    <= r4_m;
            r5_ball <= r4_ball;
            r5_rad  <= r4_rad;
            r5_wid  <= r4_wid;
        end
    end

    // stage 6: gap to the clamped point, face axis for a centre inside
    logic [35:0]        r6_ag [3];
    logic [2:0]         r6_gneg;
    t_axis              r6_ax;
    logic               r6_axneg;
    logic [31:0]        r6_lim;
    logic [63:0]        r6_r2;
    logic signed [31:0] r6_m [9];
    logic [2:0][31:0]   r6_ball;
    logic [30:0]        r6_rad;
    logic [35:0]        ag6 [3];
    logic [2:0]         gneg6;
    t_axis              ax6;
    logic               axneg6;

    always_comb begin
        logic signed [36:0] lp, wd, g;
        logic [35:0]        a [3];
        for (int i = 0; i < 3; i++) begin
            lp = 37'(r5_lp[i]);
            wd = {6'b0, r5_wid};
            if (lp > wd) begin
                g = lp - wd;
            end else if (lp < -wd) begin
                g = lp + wd;
            end else begin
                g = '0;
            end
            gneg6[i] = g[36];
            ag6[i]   = g[36] ? 36'(-g) : g[35:0];
            a[i]     = r5_lp[i][35] ? 36'(-lp) : r5_lp[i];
        end
        if (a[0] >= a[1] && a[0] >= a[2]) begin
            ax6    = AXIS_X;
            axneg6 = r5_lp[0][35];
        end else if (a[1] >= a[2]) begin
            ax6    = AXIS_Y;
            axneg6 = r5_lp[1][35];
        end else begin
            ax6    = AXIS_Z;
            axneg6 = r5_lp[2][35];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_ag    <= ag6;
            r6_gneg  <= gneg6;
            r6_ax    <= ax6;
            r6_axneg <= axneg6;
            r6_lim   <= {r5_rad, 1'b0};
            r6_r2    <= {r5_rad, 1'b0} * {r5_rad, 1'b0};
            r6_m     <= r5_m;
            r6_ball  <= r5_ball;
            r6_rad   <= r5_rad;
        end
    end

    // stage 7: squared gaps, range check, normalising shift
    logic [65:0]        r7_sq [3];
    logic               r7_over, r7_left;
    logic [4:0]         r7_amt;
    logic [32:0]        r7_ag [3];
    logic [63:0]        r7_r2;
    logic [2:0]         r7_gneg;
    t_axis              r7_ax;
    logic               r7_axneg;
    logic signed [31:0] r7_m [9];
    logic [2:0][31:0]   r7_ball;
    logic [30:0]        r7_rad;
    logic               over7, left7;
    logic [4:0]         amt7;

    always_comb begin
        logic [32:0] mx;
        logic [5:0]  pos;
        over7 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r6_ag[i] > {4'b0, r6_lim}) begin
                over7 = 1'b1;
            end
        end
        mx = r6_ag[0][32:0];
        if (r6_ag[1][32:0] > mx) begin
            mx = r6_ag[1][32:0];
        end
        if (r6_ag[2][32:0] > mx) begin
            mx = r6_ag[2][32:0];
        end
        pos = '0;
        for (int b = 0; b < 33; b++) begin
            if (mx[b]) begin
                pos = 6'(b);
            end
        end
        left7 = pos < 6'd30;
        amt7  = left7 ? 5'(6'd30 - pos) : 5'(pos - 6'd30);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r7_sq[i] <= r6_ag[i][32:0] * r6_ag[i][32:0];
                r7_ag[i] <= r6_ag[i][32:0];
            end
            r7_over  <= over7;
            r7_left  <= left7;
            r7_amt   <= amt7;
            r7_r2    <= r6_r2;
            r7_gneg  <= r6_gneg;
            r7_ax    <= r6_ax;
            r7_axneg <= r6_axneg;
            r7_m     <= r6_m;
            r7_ball  <= r6_ball;
            r7_rad   <= r6_rad;
        end
    end

    // stage 8: hit decision and normalised gap
    logic [63:0]        r8_s;
    logic               r8_hit;
    logic [30:0]        r8_an [3];
    logic [2:0]         r8_gneg;
    t_axis              r8_ax;
    logic               r8_axneg;
    logic signed [31:0] r8_m [9];
    logic [2:0][31:0]   r8_ball;
    logic [30:0]        r8_rad;
    logic [67:0]        s8;
    logic [30:0]        an8 [3];

    always_comb begin
        logic [63:0] sh;
        s8 = 68'(r7_sq[0]) + 68'(r7_sq[1]) + 68'(r7_sq[2]);
        for (int i = 0; i < 3; i++) begin
            if (r7_left) begin
                sh = 64'(r7_ag[i]) << r7_amt;
            end else begin
                sh = 64'(r7_ag[i]) >> r7_amt;
            end
            an8[i] = sh[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_s     <= s8[63:0];
            r8_hit   <= !r7_over && (s8 <= {4'b0, r7_r2});
            r8_an    <= an8;
            r8_gneg  <= r7_gneg;
            r8_ax    <= r7_ax;
            r8_axneg <= r7_axneg;
            r8_m     <= r7_m;
            r8_ball  <= r7_ball;
            r8_rad   <= r7_rad;
        end
    end

    // stage 9: squares of the normalised gap
    logic [61:0]        r9_a2 [3];
    logic [63:0]        r9_s;
    logic               r9_hit, r9_szero;
    logic [30:0]        r9_an [3];
    logic [2:0]         r9_gneg;
    t_axis              r9_ax;
    logic               r9_axneg;
    logic signed [31:0] r9_m [9];
    logic [2:0][31:0]   r9_ball;
    logic [30:0]        r9_rad;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r9_a2[i] <= r8_an[i] * r8_an[i];
            end
            r9_s     <= r8_s;
            r9_szero <= r8_s == '0;
            r9_hit   <= r8_hit;
            r9_an    <= r8_an;
            r9_gneg  <= r8_gneg;
            r9_ax    <= r8_ax;
            r9_axneg <= r8_axneg;
            r9_m     <= r8_m;
            r9_ball  <= r8_ball;
            r9_rad   <= r8_rad;
        end
    end

    // stage 10: squared length, pack sideband
    logic [63:0] r10_qs, r10_s;
    t_side       r10_side;
    t_side       side9;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            side9.m[k] = r9_m[k];
        end
        for (int i = 0; i < 3; i++) begin
            side9.an[i] = r9_an[i];
        end
        side9.ball  = r9_ball;
        side9.rad   = r9_rad;
        side9.hit   = r9_hit;
        side9.szero = r9_szero;
        side9.gneg  = r9_gneg;
        side9.ax    = r9_ax;
        side9.axneg = r9_axneg;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r10_qs   <= 64'(r9_a2[0]) + 64'(r9_a2[1]) + 64'(r9_a2[2]);
            r10_s    <= r9_s;
            r10_side <= side9;
        end
    end

    // square roots of the normalised length and of the gap
    logic [31:0] q_root, gs_root, quo;

    sbc_isqrt u_sqrt_q (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r10_qs),
        .o_root (q_root)
    );

    sbc_isqrt u_sqrt_gs (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r10_s),
        .o_root (gs_root)
    );

    t_side       r_side [SideLen];
    logic [31:0] r_gs   [DivSteps];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= r10_side;
            for (int k = 1; k < SideLen; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_gs[0] <= gs_root;
            for (int k = 1; k < DivSteps; k++) begin
                r_gs[k] <= r_gs[k-1];
            end
        end
    end

    // divide each normalised component by the length, rounding to nearest
    logic [2:0][61:0] num;
    for (genvar g = 0; g < 3; g++) begin : g_div
        logic [31:0] quo_g;
        assign num[g] = {1'b0, r_side[SqrtSteps-1].an[g], 30'b0} + 62'(q_root[31:1]);
        sbc_div u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (num[g]),
            .i_den (q_root),
            .o_quo (quo_g)
        );
        if (g == 0) begin : g_q0
            assign quo = quo_g;
        end
    end

    logic [2:0][31:0] quos;
    assign quos[0] = quo;
    assign quos[1] = g_div[1].quo_g;
    assign quos[2] = g_div[2].quo_g;

    // P1: local normal and matrix products
    t_side              sd;
    logic signed [31:0] nl [3];
    logic signed [63:0] r_p1_mn [9];
    t_side              r_p1_side;
    logic [31:0]        r_p1_gs;

    assign sd = r_side[SideLen-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nl[i] = sd.gneg[i] ? -$signed(quos[i]) : $signed(quos[i]);
        end
        if (sd.szero) begin
            for (int i = 0; i < 3; i++) begin
                nl[i] = '0;
            end
            unique case (sd.ax)
                AXIS_X:  nl[0] = sd.axneg ? -QOne : QOne;
                AXIS_Y:  nl[1] = sd.axneg ? -QOne : QOne;
                AXIS_Z:  nl[2] = sd.axneg ? -QOne : QOne;
                default: nl[0] = sd.axneg ? -QOne : QOne;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p1_mn[i*3+j] <= $signed(sd.m[i*3+j]) * nl[j];
                end
            end
            r_p1_side <= sd;
            r_p1_gs   <= r_gs[DivSteps-1];
        end
    end

    // P2: world normal
    logic signed [31:0] r_p2_nw [3];
    t_side              r_p2_side;
    logic [31:0]        r_p2_gs;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p2_nw[i] <= clamp_q(rshr(66'(r_p1_mn[i*3]) + 66'(r_p1_mn[i*3+1])
                                           + 66'(r_p1_mn[i*3+2]), 30));
            end
            r_p2_side <= r_p1_side;
            r_p2_gs   <= r_p1_gs;
        end
    end

    // P3: normal times radius
    logic signed [63:0] r_p3_nr [3];
    logic signed [31:0] r_p3_nw [3];
    t_side              r_p3_side;
    logic [31:0]        r_p3_gs;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p3_nr[i] <= r_p2_nw[i] * $signed({1'b0, r_p2_side.rad});
            end
            r_p3_nw   <= r_p2_nw;
            r_p3_side <= r_p2_side;
            r_p3_gs   <= r_p2_gs;
        end
    end

    // result: contact point and depth, zero on a miss
    always_comb begin
        logic signed [31:0] c [3];
        logic [32:0]        dd;
        for (int i = 0; i < 3; i++) begin
            c[i] = sat_i32(66'($signed(r_p3_side.ball[i])) - rshr(66'(r_p3_nr[i]), 30));
        end
        dd       = {1'b0, r_p3_side.rad, 1'b0} - {1'b0, r_p3_gs};
        n_o_data = '0;
        if (r_p3_side.hit) begin
            n_o_data.hit       = 1'b1;
            n_o_data.normal_x  = r_p3_nw[0];
            n_o_data.normal_y  = r_p3_nw[1];
            n_o_data.normal_z  = r_p3_nw[2];
            n_o_data.contact_x = c[0];
            n_o_data.contact_y = c[1];
            n_o_data.contact_z = c[2];
            n_o_data.depth     = dd[31:1];
        end
    end

    `SBC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.data.hit, (o_rsp.data.normal_x == '0) && (o_rsp.data.contact_x == '0) && (o_rsp.data.depth == '0), "miss result carries nonzero fields")
    `SBC_ASSERT_IMP(a_normal_range, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.hit, (o_rsp.data.normal_x <= QOne) && (o_rsp.data.normal_x >= -QOne) && (o_rsp.data.normal_z <= QOne) && (o_rsp.data.normal_z >= -QOne), "normal out of range")
    `SBC_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_o_valid && !o_rsp.ready && r_vld[NumStages-1], $stable(r_vld), "pipeline moved while full and stalled")

endmodule
`default_nettype wire

FILE: bench/sbc_checker.sv
// Checker for the sphere to box contact block: predicts results from requests.
// Depends on sbc_pkg and the request and result interfaces.
`default_nettype none
module sbc_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sbc_req_if        i_req,
    sbc_rsp_if        i_rsp,
    output int        o_errors,
    output int        o_pending,
    output logic      o_accept
);
    timeunit 1ns;
    timeprecision 1ps;
    import sbc_pkg::*;

    t_rsp contact_q[$];
    int   mismatches = 0;

    function automatic longint rnd_shift(input longint v, input int k);
        longint half;
        half = 64'sd1 <<< (k - 1);
        if (v >= 0) begin
            return (v + half) >>> k;
        end
        return -((-v + half) >>> k);
    endfunction

    function automatic longint lim(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned root(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_rsp predict_contact(input t_req q);
        t_rsp res;
        longint ball[3], dv[3], lp[3], g[3], nl[3], e[9], m[9];
        longint unsigned ag[3];
        longint w, x, y, z, one, wid, rad, acc, c, a0, a1, a2, n, tmp;
        longint unsigned r2, lm, s, gs, mx, qq, sq;
        int ax;
        res = '0;
        ball[0] = q.ball_x; ball[1] = q.ball_y; ball[2] = q.ball_z;
        dv[0] = ball[0] - longint'(q.box_x);
        dv[1] = ball[1] - longint'(q.box_y);
        dv[2] = ball[2] - longint'(q.box_z);
        rad = longint'({1'b0, q.ball_radius});
        wid = longint'({1'b0, q.box_width});
        w = lim(q.box_qw, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        x = lim(q.box_qx, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        y = lim(q.box_qy, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        z = lim(q.box_qz, -(64'sd1 <<< 30), 64'sd1 <<< 30);
        one = 64'sd1 <<< 60;
        e[0] = one - 2 * (y * y + z * z); e[1] = 2 * (x * y - w * z);
        e[2] = 2 * (x * z + w * y);       e[3] = 2 * (x * y + w * z);
        e[4] = one - 2 * (x * x + z * z); e[5] = 2 * (y * z - w * x);
        e[6] = 2 * (x * z - w * y);       e[7] = 2 * (y * z + w * x);
        e[8] = one - 2 * (x * x + y * y);
        for (int i = 0; i < 9; i++) begin
            m[i] = lim(rnd_shift(e[i], 30), -(64'sd1 <<< 30), 64'sd1 <<< 30);
        end
        for (int i = 0; i < 3; i++) begin
            lp[i] = 0;
            for (int j = 0; j < 3; j++) begin
                lp[i] += rnd_shift(m[j * 3 + i] * dv[j], 29);
            end
            if (lp[i] > wid) begin
                g[i] = lp[i] - wid;
            end else if (lp[i] < -wid) begin
                g[i] = lp[i] + wid;
            end else begin
                g[i] = 0;
            end
            ag[i] = g[i] < 0 ? -g[i] : g[i];
        end
        lm = 2 * rad;
        r2 = lm * lm;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (ag[i] > lm) begin
                return res;
            end
            sq = ag[i] * ag[i];
            if (sq > r2 - s) begin
                return res;
            end
            s += sq;
        end
        if (s == 0) begin
            a0 = lp[0] < 0 ? -lp[0] : lp[0];
            a1 = lp[1] < 0 ? -lp[1] : lp[1];
            a2 = lp[2] < 0 ? -lp[2] : lp[2];
            if (a0 >= a1 && a0 >= a2) begin
                ax = 0;
            end else if (a1 >= a2) begin
                ax = 1;
            end else begin
                ax = 2;
            end
            nl[0] = 0; nl[1] = 0; nl[2] = 0;
            nl[ax] = lp[ax] < 0 ? -(64'sd1 <<< 30) : (64'sd1 <<< 30);
        end else begin
            mx = ag[0];
            if (ag[1] > mx) mx = ag[1];
            if (ag[2] > mx) mx = ag[2];
            while (mx < (64'd1 << 30)) begin
                for (int i = 0; i < 3; i++) ag[i] = ag[i] << 1;
                mx = mx << 1;
            end
            while (mx >= (64'd1 << 31)) begin
                for (int i = 0; i < 3; i++) ag[i] = ag[i] >> 1;
                mx = mx >> 1;
            end
            qq = root(ag[0] * ag[0] + ag[1] * ag[1] + ag[2] * ag[2]);
            for (int i = 0; i < 3; i++) begin
                n = ((ag[i] << 30) + (qq >> 1)) / qq;
                nl[i] = g[i] < 0 ? -n : n;
            end
        end
        gs = root(s);
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                acc += m[i * 3 + j] * nl[j];
            end
            tmp = lim(rnd_shift(acc, 30), -(64'sd1 <<< 30), 64'sd1 <<< 30);
            c = lim(ball[i] - rnd_shift(tmp * rad, 30), -64'sd2147483648, 64'sd2147483647);
            case (i)
                0: begin res.normal_x = tmp[31:0]; res.contact_x = c[31:0]; end
                1: begin res.normal_y = tmp[31:0]; res.contact_y = c[31:0]; end
                default: begin res.normal_z = tmp[31:0]; res.contact_z = c[31:0]; end
            endcase
        end
        res.depth = 31'((lm - gs) >> 1);
        return res;
    endfunction

    assign o_errors  = mismatches;
    assign o_pending = contact_q.size();
    assign o_accept  = (i_req.valid && i_req.ready) || (i_rsp.valid && i_rsp.ready);

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && i_req.valid && i_req.ready) begin
            contact_q.insert(contact_q.size(), predict_contact(i_req.data));
        end
        if (i_rst_n && i_rsp.valid && i_rsp.ready) begin
            if (contact_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", i_rsp.data);
            end else begin
                want = contact_q.pop_front();
                if (want.hit !== i_rsp.data.hit || want.normal_x !== i_rsp.data.normal_x
                    || want.normal_y !== i_rsp.data.normal_y
                    || want.normal_z !== i_rsp.data.normal_z
                    || want.contact_x !== i_rsp.data.contact_x
                    || want.contact_y !== i_rsp.data.contact_y
                    || want.contact_z !== i_rsp.data.contact_z
                    || want.depth !== i_rsp.data.depth) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %p", want);
                        $display("          actual   %p", i_rsp.data);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb_sphere_box_contact.sv
// Top of the sphere to box contact bench: clock, reset, requests and verdict.
// Depends on sbc_pkg, the interfaces, the block and sbc_checker.
`default_nettype none
module tb_sphere_box_contact;
    timeunit 1ns;
    timeprecision 1ps;
    import sbc_pkg::*;

    localparam int Latency = 78;
    localparam int IdleLimit = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, idle_cycles;
    logic accept;
    int   send_idle = 0;
    int   recv_idle = 0;
    logic hold_off = 1'b0;
    bit   stim_done = 1'b0;

    sbc_req_if req_if ();
    sbc_rsp_if rsp_if ();

    sphere_box_contact u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    sbc_checker u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req_if),
        .i_rsp    (rsp_if),
        .o_errors (errors),
        .o_pending(pending),
        .o_accept (accept)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || accept) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IdleLimit) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_quat();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2) == 0 ? QOne : -QOne;
            default: return $signed($urandom_range(32'h7FFF_FFFF)) - QOne;
        endcase
    endfunction

    // mostly near pairs so that hits are common
    function automatic t_req rand_pair();
        t_req q;
        int   span;
        span = $urandom_range(3) == 0 ? 31 : $urandom_range(22, 10);
        q.box_x = $urandom;
        q.box_y = $urandom;
        q.box_z = $urandom;
        if ($urandom_range(9) == 0) begin
            q.ball_x = $urandom; q.ball_y = $urandom; q.ball_z = $urandom;
        end else begin
            q.ball_x = q.box_x + ($signed($urandom) >>> (31 - span));
            q.ball_y = q.box_y + ($signed($urandom) >>> (31 - span));
            q.ball_z = q.box_z + ($signed($urandom) >>> (31 - span));
        end
        q.ball_radius = 31'($urandom >> (31 - span));
        q.box_width   = 31'($urandom >> (31 - span));
        if ($urandom_range(9) == 0) begin
            q.ball_radius = 31'($urandom);
            q.box_width   = 31'($urandom);
        end
        q.box_qw = rand_quat();
        q.box_qx = rand_quat();
        q.box_qy = rand_quat();
        q.box_qz = rand_quat();
        if ($urandom_range(4) == 0) begin
            q.box_qw = QOne; q.box_qx = 0; q.box_qy = 0; q.box_qz = 0;
        end
        return q;
    endfunction

    // hold valid high after the request is taken; the caller drops it
    task automatic send(input t_req q);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic directed();
        t_req q;
        q = '0;
        q.box_qw = QOne;
        send(q);
        q.ball_radius = 31'h7FFF_FFFF; q.box_width = 31'h7FFF_FFFF;
        send(q);
        q.ball_x = 32'sh7FFF_FFFF; q.box_x = 32'sh8000_0000;
        send(q);
        q.ball_y = 32'sh8000_0000; q.box_y = 32'sh7FFF_FFFF; q.ball_z = -1;
        send(q);
        q = '0; q.box_qw = QOne; q.box_width = 31'h20000;
        q.ball_x = 32'sh8000; q.ball_radius = 31'h10000;
        send(q);
        q.ball_x = -32'sh8000;
        send(q);
        q.ball_x = 0; q.ball_y = 32'sh8000;
        send(q);
        q.ball_y = 0; q.ball_z = -32'sh8000;
        send(q);
        q.ball_z = 32'sh8000; q.ball_x = 32'sh8000;
        send(q);
        q = '0; q.box_qw = QOne; q.box_width = 31'h20000;
        q.ball_x = 32'sh30000;
        send(q);
        q.ball_radius = 31'h20000;
        send(q);
        q.ball_radius = 31'h10000;
        send(q);
        q.ball_x = 32'sh40000;
        send(q);
        q.box_qw = 0; q.box_qz = QOne;
        send(q);
        q.box_qw = 32'sh7FFF_FFFF; q.box_qx = 32'sh8000_0000;
        q.box_qy = 32'sh7FFF_FFFF; q.box_qz = 32'sh8000_0000;
        send(q);
        q.box_qw = 32'sh2000_0000; q.box_qx = 0; q.box_qy = 0; q.box_qz = 0;
        q.ball_x = 32'sh7FFF_0000; q.ball_radius = 31'h7FFF_FFFF;
        send(q);
        q = '0; q.box_qw = -QOne; q.ball_radius = 31'h5_0000;
        q.ball_x = 32'sh1_0000; q.ball_y = 32'sh2_0000; q.ball_z = 32'sh3_0000;
        send(q);
        q.box_qw = QOne >>> 1; q.box_qx = QOne >>> 1; q.box_qy = QOne >>> 1;
        q.box_qz = QOne >>> 1;
        send(q);
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        directed();
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 34 : (phase == 1 ? 86 : 0);
            recv_idle = phase == 0 ? 86 : (phase == 1 ? 34 : 0);
            for (int n = 0; n < 380; n++) begin
                send(rand_pair());
            end
        end
        send_idle = 0;
        recv_idle = 0;
        hold_off  = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < 150; n++) begin
                    send(rand_pair());
                end
                req_if.valid <= 1'b0;
            end
        join
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
